@@ hdl/spc_pkg.sv @@
// Shared types and constants for the stereo pair line compositor.
// Holds the register map, the geometry bundle passed from the config block
// and the generator constants. No dependencies.
package spc_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_FIELD_W = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEFT_WIDTH   = 3'd0,
        REG_RIGHT_WIDTH  = 3'd1,
        REG_SEPARATION   = 3'd2,
        REG_FRAME_HEIGHT = 3'd3,
        REG_LEFT_HEIGHT  = 3'd4,
        REG_RIGHT_HEIGHT = 3'd5,
        REG_SPOT_WIDTH   = 3'd6,
        REG_SPOT_HEIGHT  = 3'd7
    } spc_reg_t;

    // Signed width of column geometry; covers three full-size widths plus a spot
    localparam int GEO_W = 14;
    // Signed width of the spot row boundary
    localparam int YB_W  = 12;

    localparam logic [7:0] PIX_BLANK = 8'hFF;
    localparam logic [7:0] PIX_BLACK = 8'h00;

    // Row geometry and column boundaries, all for the current configuration
    typedef struct packed {
        logic                          sep_neg;
        logic signed [GEO_W-1:0]       l_end;
        logic signed [GEO_W-1:0]       xw;
        logic signed [GEO_W-1:0]       wm1;
        logic signed [GEO_W-1:0]       xbl;
        logic signed [GEO_W-1:0]       xtl;
        logic signed [GEO_W-1:0]       xbr;
        logic signed [GEO_W-1:0]       xtr;
        logic [CFG_FIELD_W-1:0]        hm1;
        logic signed [YB_W-1:0]        yb;
        logic [CFG_FIELD_W-1:0]        left_height;
        logic [CFG_FIELD_W-1:0]        right_height;
    } spc_geo_t;

    // Multiplicative congruential generator
    localparam int RNG_W      = 21;
    localparam int RNG_PROD_W = 42;
    localparam int RNG_RED_W  = 23;
    localparam logic [63:0] RNG_MOD  = 64'd1234589;
    localparam logic [63:0] RNG_MUL  = 64'd3432;
    localparam logic [63:0] RNG_SEED = 64'd4567;

    // First three states after the seed, and the multiplier for four steps
    localparam logic [63:0] RNG_S1 = (RNG_MUL * RNG_SEED) % RNG_MOD;
    localparam logic [63:0] RNG_S2 = (RNG_MUL * RNG_S1) % RNG_MOD;
    localparam logic [63:0] RNG_S3 = (RNG_MUL * RNG_S2) % RNG_MOD;
    localparam logic [63:0] RNG_A2 = (RNG_MUL * RNG_MUL) % RNG_MOD;
    localparam logic [63:0] RNG_A4 = (RNG_A2 * RNG_A2) % RNG_MOD;

    // Reciprocal for quotient estimate: floor(2^41 / modulus)
    localparam logic [63:0] RNG_RECIP = (64'd1 << 41) / RNG_MOD;

    // draw = 256*state/modulus exceeds 128 exactly when state reaches this
    localparam logic [63:0] RNG_PICK_MIN = (64'd129 * RNG_MOD + 64'd255) / 64'd256;

endpackage

@@ hdl/stereo_pair_line_compositor.sv @@
// Top level of the stereo pair line compositor: input register, pixel
// selection, result register. Depends on spc_pkg, spc_cfg and spc_rng.
//
// Usage: one request on the input channel carries the left and right RGB
// pixels aligned to the next output column; one request leaves on the
// output channel with the composed pixel, end_of_row and end_of_frame.
// Columns run left image, gap or overlap zone, right image; rows run to
// frame_height, then the frame restarts.
// Path: a request passes the input register, then the result register.
// Throughput: one request per cycle while out_stall is low; the column/row
// counters and the overlap generator never hold the flow.
// Stall: while out_stall is high the result register holds; one more
// request is taken into the input register, after which in_stall rises.
// Reset: configuration returns to its defaults, counters go to column 0
// of row 0 and the generator to its seed. Write configuration only while
// no request is in flight; a write passes the config and geometry registers.
module stereo_pair_line_compositor
    import spc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             left_red,
    input  logic [7:0]             left_green,
    input  logic [7:0]             left_blue,
    input  logic [7:0]             right_red,
    input  logic [7:0]             right_green,
    input  logic [7:0]             right_blue,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_red,
    output logic [7:0]             out_green,
    output logic [7:0]             out_blue,
    output logic                   end_of_row,
    output logic                   end_of_frame
);

    localparam int FIELD_MAX = (1 << CFG_FIELD_W) - 1;
    localparam int WMAX      = (MAX_WIDTH < FIELD_MAX) ? MAX_WIDTH : FIELD_MAX;
    localparam int HMAX      = (MAX_HEIGHT < FIELD_MAX) ? MAX_HEIGHT : FIELD_MAX;
    localparam int CW        = $clog2(3 * WMAX);
    localparam int RW        = $clog2(HMAX);

    spc_geo_t geo;
    logic     pick_left;
    logic     rng_advance;

    // Input register
    logic        s1_valid_reg, s1_valid_next;
    logic [23:0] lpix_reg, rpix_reg;
    logic        s1_go, in_take, out_take;

    // Counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [23:0] opix_reg, opix_next;
    logic        eor_reg, eof_reg;

    // Per-pixel work
    logic signed [GEO_W-1:0] col_s, x_s;
    logic [CFG_FIELD_W-1:0]  row11, y11;
    logic signed [YB_W-1:0]  y_s;
    logic                    below_spot, spot_l, spot_r, black;
    logic                    eor, last_row;
    logic [23:0]             lp, rp, pix;
    logic                    l_blank, r_blank, in_overlap;

    spc_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geo       (geo)
    );

    spc_rng u_rng (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (rng_advance),
        .pick_left (pick_left)
    );

    // Handshake: move the input register on when the result slot frees up
    assign out_take      = out_valid_reg && !out_stall;
    assign s1_go         = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall      = s1_valid_reg && !s1_go;
    assign in_take       = in_valid && !in_stall;
    assign s1_valid_next = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_go ? 1'b1 : (out_take ? 1'b0 : out_valid_reg);

    // Position, with counters past the frame pinned to the last column/row
    always_comb
    begin
        col_s = signed'(GEO_W'(col_reg));
        x_s   = (col_s > geo.wm1) ? geo.wm1 : col_s;
        row11 = CFG_FIELD_W'(row_reg);
        y11   = (row11 > geo.hm1) ? geo.hm1 : row11;
        y_s   = signed'(YB_W'(y11));

        eor      = (x_s == geo.wm1);
        last_row = (y11 == geo.hm1);

        below_spot = (y_s > geo.yb);
        spot_l     = (x_s > geo.xbl) && (x_s < geo.xtl) && below_spot;
        spot_r     = (x_s > geo.xbr) && (x_s < geo.xtr) && below_spot;
    end

    // Source pixels, blank below each image's height
    always_comb
    begin
        lp = (y11 >= geo.left_height)  ? {3{PIX_BLANK}} : lpix_reg;
        rp = (y11 >= geo.right_height) ? {3{PIX_BLANK}} : rpix_reg;
        l_blank = (lp == {3{PIX_BLANK}});
        r_blank = (rp == {3{PIX_BLANK}});
    end

    // Pick the pixel for this column
    always_comb
    begin
        in_overlap = 1'b0;
        if (!geo.sep_neg)
        begin
            priority if (x_s < geo.l_end)
            begin
                pix   = lp;
                black = spot_l;
            end
            else if (x_s < geo.xw)
            begin
                pix   = {3{PIX_BLANK}};
                black = 1'b0;
            end
            else
            begin
                pix   = rp;
                black = spot_r;
            end
        end
        else
        begin
            black = spot_l || spot_r;
            priority if (x_s < geo.xw)
                pix = lp;
            else if (x_s < geo.l_end)
            begin
                in_overlap = 1'b1;
                priority if (l_blank)
                    pix = rp;
                else if (r_blank)
                    pix = lp;
                else
                    pix = pick_left ? lp : rp;
            end
            else
                pix = rp;
        end
        opix_next = black ? {3{PIX_BLACK}} : pix;
    end

    // Draw only when an overlap pixel has two real candidates
    assign rng_advance = s1_go && in_overlap && !l_blank && !r_blank;

    // Advance counters with each finished request
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (s1_go)
        begin
            if (eor)
            begin
                col_next = '0;
                row_next = last_row ? '0 : (y11[RW-1:0] + RW'(1));
            end
            else
                col_next = x_s[CW-1:0] + CW'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    // Payload: capture inputs, load results
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            lpix_reg <= {left_red, left_green, left_blue};
            rpix_reg <= {right_red, right_green, right_blue};
        end
        if (s1_go)
        begin
            opix_reg <= opix_next;
            eor_reg  <= eor;
            eof_reg  <= eor && last_row;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_red      = opix_reg[23:16];
    assign out_green    = opix_reg[15:8];
    assign out_blue     = opix_reg[7:0];
    assign end_of_row   = eor_reg;
    assign end_of_frame = eof_reg;

endmodule

@@ hdl/spc_cfg.sv @@
// Configuration registers and derived row geometry for the compositor.
// Depends on spc_pkg for the register map and the geometry bundle.
module spc_cfg
    import spc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output spc_geo_t               geo
);

    // Largest value an 11-bit field can carry after clamping
    localparam int FIELD_MAX = (1 << CFG_FIELD_W) - 1;
    localparam int WCAP_I    = (MAX_WIDTH < FIELD_MAX) ? MAX_WIDTH : FIELD_MAX;
    localparam int HCAP_I    = (MAX_HEIGHT < FIELD_MAX) ? MAX_HEIGHT : FIELD_MAX;
    localparam logic [CFG_FIELD_W-1:0] WCAP = CFG_FIELD_W'(WCAP_I);
    localparam logic [CFG_FIELD_W-1:0] HCAP = CFG_FIELD_W'(HCAP_I);
    localparam logic [CFG_FIELD_W-1:0] W_RST = CFG_FIELD_W'((WCAP_I < 1024) ? WCAP_I : 1024);
    localparam logic [CFG_FIELD_W-1:0] H_RST = CFG_FIELD_W'((HCAP_I < 1024) ? HCAP_I : 1024);
    localparam logic [CFG_FIELD_W-1:0] DIM_RST  = CFG_FIELD_W'(1024);
    localparam logic [CFG_FIELD_W-1:0] SPOT_RST = CFG_FIELD_W'(10);

    logic [CFG_FIELD_W-1:0] lw_reg, rw_reg, fh_reg, lh_reg, rh_reg, sw_reg, sh_reg;
    logic [CFG_DATA_W-1:0]  sep_reg;
    logic [CFG_FIELD_W-1:0] field;
    logic [CFG_FIELD_W-1:0] lw_clamped, rw_clamped, fh_clamped;

    logic signed [GEO_W-1:0] lw_s, rw_s, sw_s, minw_s, sep_s, sep_c, wcap_s;
    logic signed [GEO_W-1:0] xw;
    spc_geo_t                geo_next, geo_reg;

    // Halve with rounding toward zero
    function automatic logic signed [GEO_W-1:0] half_trunc(input logic signed [GEO_W-1:0] v);
        half_trunc = v[GEO_W-1] ? ((v + GEO_W'(1)) >>> 1) : (v >>> 1);
    endfunction

    // Clamp incoming widths and frame height at write time
    always_comb
    begin
        field = cfg_data[CFG_FIELD_W-1:0];
        if (field == '0)
            lw_clamped = CFG_FIELD_W'(1);
        else if (field > WCAP)
            lw_clamped = WCAP;
        else
            lw_clamped = field;
        rw_clamped = lw_clamped;
        if (field == '0)
            fh_clamped = CFG_FIELD_W'(1);
        else if (field > HCAP)
            fh_clamped = HCAP;
        else
            fh_clamped = field;
    end

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg  <= W_RST;
            rw_reg  <= W_RST;
            sep_reg <= '0;
            fh_reg  <= H_RST;
            lh_reg  <= DIM_RST;
            rh_reg  <= DIM_RST;
            sw_reg  <= SPOT_RST;
            sh_reg  <= SPOT_RST;
        end
        else if (cfg_write)
        begin
            unique case (spc_reg_t'(cfg_index))
                REG_LEFT_WIDTH:   lw_reg  <= lw_clamped;
                REG_RIGHT_WIDTH:  rw_reg  <= rw_clamped;
                REG_SEPARATION:   sep_reg <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg  <= fh_clamped;
                REG_LEFT_HEIGHT:  lh_reg  <= field;
                REG_RIGHT_HEIGHT: rh_reg  <= field;
                REG_SPOT_WIDTH:   sw_reg  <= field;
                REG_SPOT_HEIGHT:  sh_reg  <= field;
            endcase
        end
    end

    // Derive column boundaries and row limits
    always_comb
    begin
        lw_s   = signed'(GEO_W'(lw_reg));
        rw_s   = signed'(GEO_W'(rw_reg));
        sw_s   = signed'(GEO_W'(sw_reg));
        wcap_s = signed'(GEO_W'(WCAP));
        sep_s  = GEO_W'(signed'(sep_reg));
        minw_s = (lw_s < rw_s) ? lw_s : rw_s;

        // Limit overlap to the narrower image and the gap to the max width
        if (sep_s < -minw_s)
            sep_c = -minw_s;
        else if (sep_s > wcap_s)
            sep_c = wcap_s;
        else
            sep_c = sep_s;

        xw = lw_s + sep_c;

        geo_next.sep_neg      = sep_c[GEO_W-1];
        geo_next.l_end        = lw_s;
        geo_next.xw           = xw;
        geo_next.wm1          = xw + rw_s - GEO_W'(1);
        geo_next.xbl          = half_trunc(lw_s - sw_s);
        geo_next.xtl          = (lw_s + sw_s) >>> 1;
        geo_next.xbr          = xw + half_trunc(rw_s - sw_s);
        geo_next.xtr          = xw + ((rw_s + sw_s) >>> 1);
        geo_next.hm1          = fh_reg - CFG_FIELD_W'(1);
        geo_next.yb           = signed'(YB_W'(fh_reg)) - signed'(YB_W'(sh_reg));
        geo_next.left_height  = lh_reg;
        geo_next.right_height = rh_reg;
    end

    // Hold derived geometry in a register behind the configuration registers
    always_ff @(posedge clk)
    begin
        geo_reg <= geo_next;
    end

    assign geo = geo_reg;

endmodule

@@ hdl/spc_rng.sv @@
// Congruential generator run as a four-stage ring, each lap one multiply
// by the four-step multiplier. Depends on spc_pkg for the constants.
module spc_rng
    import spc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    output logic pick_left
);

    localparam logic [RNG_W-1:0]     A4_C    = RNG_W'(RNG_A4);
    localparam logic [RNG_W-1:0]     RECIP_C = RNG_W'(RNG_RECIP);
    localparam logic [RNG_W-1:0]     MOD_C   = RNG_W'(RNG_MOD);
    localparam logic [RNG_W-1:0]     PICK_C  = RNG_W'(RNG_PICK_MIN);
    localparam logic [RNG_RED_W-1:0] M1      = RNG_RED_W'(RNG_MOD);
    localparam logic [RNG_RED_W-1:0] M2      = RNG_RED_W'(RNG_MOD * 64'd2);
    localparam logic [RNG_RED_W-1:0] M3      = RNG_RED_W'(RNG_MOD * 64'd3);

    logic [RNG_W-1:0]        a_reg, a_next;
    logic [RNG_PROD_W-2:0]   b_reg, b_next;
    logic [RNG_PROD_W-2:0]   cp_reg, cp_next;
    logic [RNG_W-1:0]        cq_reg, cq_next;
    logic [RNG_RED_W-1:0]    d_reg, d_next;
    logic [RNG_PROD_W-1:0]   b_prod, q_prod, d_diff;
    logic [RNG_RED_W-1:0]    r_full;
    logic [RNG_W-1:0]        state;

    // Ring stages: multiply, estimate quotient, subtract, correct
    always_comb
    begin
        b_prod  = RNG_PROD_W'(a_reg) * RNG_PROD_W'(A4_C);
        b_next  = b_prod[RNG_PROD_W-2:0];

        q_prod  = RNG_PROD_W'(b_reg[RNG_PROD_W-2:RNG_W-1]) * RNG_PROD_W'(RECIP_C);
        cq_next = q_prod[RNG_PROD_W-1:RNG_W];
        cp_next = b_reg;

        d_diff  = RNG_PROD_W'(cp_reg) - RNG_PROD_W'(cq_reg) * RNG_PROD_W'(MOD_C);
        d_next  = d_diff[RNG_RED_W-1:0];

        // Estimate falls short by at most a few moduli
        priority if (d_reg >= M3)
            r_full = d_reg - M3;
        else if (d_reg >= M2)
            r_full = d_reg - M2;
        else if (d_reg >= M1)
            r_full = d_reg - M1;
        else
            r_full = d_reg;

        state  = r_full[RNG_W-1:0];
        a_next = state;
    end

    // Advance the ring only when a draw is taken; reset preloads the first three states after the seed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= RNG_W'(RNG_SEED);
            b_reg  <= (RNG_PROD_W-1)'(RNG_S3);
            cp_reg <= (RNG_PROD_W-1)'(RNG_S2);
            cq_reg <= '0;
            d_reg  <= RNG_RED_W'(RNG_S1);
        end
        else if (advance)
        begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            cp_reg <= cp_next;
            cq_reg <= cq_next;
            d_reg  <= d_next;
        end
    end

    assign pick_left = (state >= PICK_C);

endmodule
